### sv/swam_pkg.sv
`timescale 1ns / 1ps

package swam_pkg;

  localparam int MAX_LEN  = 4096;
  localparam int ALPHABET = 26;

  localparam int LEN_W    = $clog2(MAX_LEN + 1);
  localparam int PTR_W    = $clog2(MAX_LEN);
  localparam int LETTER_W = 5;
  localparam int DIFF_W   = $clog2(ALPHABET + 1);

  typedef logic [LETTER_W-1:0] letter_t;
  typedef logic [LEN_W-1:0]    len_t;
  typedef logic [PTR_W-1:0]    ptr_t;
  typedef logic [DIFF_W-1:0]   diff_t;

  typedef enum logic [1:0] {
    OP_CLEAR   = 2'd0,
    OP_PATTERN = 2'd1,
    OP_TEXT    = 2'd2
  } op_t;

  // One decoded request on its way from the window control to the count stage.
  typedef struct packed {
    logic    clr;     // clear everything
    logic    pat;     // pattern letter taken into the pattern
    logic    txt;     // text letter entering the window
    logic    evict;   // the oldest window letter leaves
    logic    full;    // window is full after this request
    logic    ovf;     // pattern letter dropped
    letter_t letter;
    letter_t old;     // letter leaving the window
  } item_t;

endpackage

### sv/swam_front.sv
`timescale 1ns / 1ps

module swam_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_accept,
  input  logic [1:0]        in_op,
  input  swam_pkg::letter_t in_letter,
  input  logic              adv,
  output swam_pkg::item_t   item_o,
  output logic              item_valid_o
);

  swam_pkg::len_t    plen_r, plen_nxt;
  swam_pkg::len_t    seen_r, seen_nxt;
  swam_pkg::ptr_t    wp_r, wp_nxt;
  swam_pkg::ptr_t    rd_addr;
  logic [swam_pkg::LEN_W:0] rd_sum;
  logic              wr_en;
  logic              letter_ok;
  swam_pkg::item_t   s1_r, s1_nxt;
  logic              s1_valid_r;
  swam_pkg::letter_t hist_q_r;
  swam_pkg::letter_t hist_mem [swam_pkg::MAX_LEN];

  assign letter_ok = in_letter < swam_pkg::LETTER_W'(swam_pkg::ALPHABET);

  // The oldest window letter sits pattern_length slots behind the write pointer.
  assign rd_sum  = (swam_pkg::LEN_W + 1)'(wp_r) + (swam_pkg::LEN_W + 1)'(swam_pkg::MAX_LEN)
                 - (swam_pkg::LEN_W + 1)'(plen_r);
  assign rd_addr = (rd_sum >= (swam_pkg::LEN_W + 1)'(swam_pkg::MAX_LEN))
                 ? swam_pkg::PTR_W'(rd_sum - (swam_pkg::LEN_W + 1)'(swam_pkg::MAX_LEN))
                 : swam_pkg::PTR_W'(rd_sum);

  always_comb begin
    plen_nxt      = plen_r;
    seen_nxt      = seen_r;
    wp_nxt        = wp_r;
    wr_en         = 1'b0;
    s1_nxt        = '0;
    s1_nxt.letter = in_letter;
    case (in_op)
      swam_pkg::OP_CLEAR: begin
        plen_nxt   = '0;
        seen_nxt   = '0;
        wp_nxt     = '0;
        s1_nxt.clr = 1'b1;
      end
      swam_pkg::OP_PATTERN: begin
        if (letter_ok) begin
          if (plen_r == swam_pkg::LEN_W'(swam_pkg::MAX_LEN)) begin
            s1_nxt.ovf = 1'b1;
          end else begin
            plen_nxt   = plen_r + 1'b1;
            seen_nxt   = '0;
            wp_nxt     = '0;
            s1_nxt.pat = 1'b1;
          end
        end
      end
      swam_pkg::OP_TEXT: begin
        if (letter_ok && plen_r != '0) begin
          s1_nxt.txt = 1'b1;
          wr_en      = 1'b1;
          if (seen_r == plen_r) begin
            s1_nxt.evict = 1'b1;
          end else begin
            seen_nxt = seen_r + 1'b1;
          end
          wp_nxt = (wp_r == swam_pkg::PTR_W'(swam_pkg::MAX_LEN - 1)) ? '0 : wp_r + 1'b1;
        end
      end
      default: ;
    endcase
    s1_nxt.full = (plen_nxt != '0) && (seen_nxt == plen_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plen_r     <= '0;
      seen_r     <= '0;
      wp_r       <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      if (in_accept) begin
        plen_r <= plen_nxt;
        seen_r <= seen_nxt;
        wp_r   <= wp_nxt;
      end
      if (adv) begin
        s1_valid_r <= in_accept;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r <= s1_nxt;
    end
  end

  // Read comes before write, so a full-length window sees the slot it overwrites.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      hist_q_r <= hist_mem[rd_addr];
      if (wr_en) begin
        hist_mem[wp_r] <= in_letter;
      end
    end
  end

  always_comb begin
    item_o     = s1_r;
    item_o.old = hist_q_r;
  end

  assign item_valid_o = s1_valid_r;

endmodule

### sv/swam_count.sv
`timescale 1ns / 1ps

module swam_count (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  swam_pkg::item_t item_i,
  input  logic            item_valid_i,
  output logic            out_valid_o,
  output logic            match_o,
  output logic            found_o,
  output logic            ovf_o
);

  swam_pkg::len_t pc_r [swam_pkg::ALPHABET];
  swam_pkg::len_t pc_nxt [swam_pkg::ALPHABET];
  swam_pkg::len_t wc_r [swam_pkg::ALPHABET];
  swam_pkg::len_t wc_nxt [swam_pkg::ALPHABET];
  swam_pkg::diff_t distinct_r, distinct_nxt;
  swam_pkg::diff_t diff_r, diff_nxt;
  logic            found_r, found_nxt;
  logic            out_valid_r, match_r, ovf_r;
  logic            match_nxt;
  logic            update;

  assign update = adv && item_valid_i;

  always_comb begin
    logic           old_ok;
    logic           before1, after1, before2, after2;
    swam_pkg::len_t w1, wl, w2;
    swam_pkg::diff_t d1, d2;
    for (int k = 0; k < swam_pkg::ALPHABET; k++) begin
      pc_nxt[k] = pc_r[k];
      wc_nxt[k] = wc_r[k];
    end
    distinct_nxt = distinct_r;
    diff_nxt     = diff_r;
    found_nxt    = found_r;
    old_ok  = item_i.evict && (item_i.old < swam_pkg::LETTER_W'(swam_pkg::ALPHABET));
    before1 = 1'b0;
    after1  = 1'b0;
    before2 = 1'b0;
    after2  = 1'b0;
    w1      = '0;
    wl      = '0;
    w2      = '0;
    d1      = diff_r;
    d2      = diff_r;
    if (item_i.clr) begin
      for (int k = 0; k < swam_pkg::ALPHABET; k++) begin
        pc_nxt[k] = '0;
        wc_nxt[k] = '0;
      end
      distinct_nxt = '0;
      diff_nxt     = '0;
      found_nxt    = 1'b0;
    end else if (item_i.pat) begin
      pc_nxt[item_i.letter] = pc_r[item_i.letter] + 1'b1;
      for (int k = 0; k < swam_pkg::ALPHABET; k++) begin
        wc_nxt[k] = '0;
      end
      if (pc_r[item_i.letter] == '0) begin
        distinct_nxt = distinct_r + 1'b1;
      end
      // An empty window differs from the pattern in every letter it uses.
      diff_nxt  = distinct_nxt;
      found_nxt = 1'b0;
    end else if (item_i.txt) begin
      // The leaving letter is counted down first, then the new one up.
      if (old_ok) begin
        before1 = wc_r[item_i.old] == pc_r[item_i.old];
        w1      = (wc_r[item_i.old] != '0) ? wc_r[item_i.old] - 1'b1 : wc_r[item_i.old];
        after1  = w1 == pc_r[item_i.old];
        if (before1 && !after1) begin
          d1 = diff_r + 1'b1;
        end else if (!before1 && after1 && diff_r != '0) begin
          d1 = diff_r - 1'b1;
        end
        wc_nxt[item_i.old] = w1;
      end
      wl      = (old_ok && item_i.old == item_i.letter) ? w1 : wc_r[item_i.letter];
      before2 = wl == pc_r[item_i.letter];
      w2      = wl + 1'b1;
      after2  = w2 == pc_r[item_i.letter];
      d2      = d1;
      if (before2 && !after2) begin
        d2 = d1 + 1'b1;
      end else if (!before2 && after2 && d1 != '0) begin
        d2 = d1 - 1'b1;
      end
      wc_nxt[item_i.letter] = w2;
      diff_nxt = d2;
      if (item_i.full && d2 == '0) begin
        found_nxt = 1'b1;
      end
    end
    match_nxt = item_i.full && (diff_nxt == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < swam_pkg::ALPHABET; k++) begin
        pc_r[k] <= '0;
        wc_r[k] <= '0;
      end
      distinct_r  <= '0;
      diff_r      <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (update) begin
        for (int k = 0; k < swam_pkg::ALPHABET; k++) begin
          pc_r[k] <= pc_nxt[k];
          wc_r[k] <= wc_nxt[k];
        end
        distinct_r <= distinct_nxt;
        diff_r     <= diff_nxt;
        found_r    <= found_nxt;
      end
      if (adv) begin
        out_valid_r <= item_valid_i;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (update) begin
      match_r <= match_nxt;
      ovf_r   <= item_i.ovf;
    end
  end

  assign out_valid_o = out_valid_r;
  assign match_o     = match_r;
  assign found_o     = found_r;
  assign ovf_o       = ovf_r;

endmodule

### sv/sliding_window_anagram_match_unit.sv
// Pipeline: a request accepted by the front stage is decoded and its history slot read into
// registers, then the count stage registers the result that drives out_tdata.
// Throughput: one request per cycle unless out_tready holds the pipeline; the history memory
// is read and written on accept, and the letter counts are updated as the item enters the count stage.
// Reset: synchronous, active low; clears all counts, lengths, pointers, valid flags and found.
// The history memory is not cleared; only slots written since a restart are read.
`timescale 1ns / 1ps

module sliding_window_anagram_match_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [4:0] letter, [7:5] zero
  input  logic [1:0] in_tuser,   // [1:0] op
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata   // [0] window_match, [1] found, [2] overflow, [7:3] zero
);

  logic            adv;
  logic            in_accept;
  swam_pkg::item_t item;
  logic            item_valid;
  logic            match, found, ovf;

  // Both stages move whenever the result register is empty or being taken.
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;
  assign in_accept = in_tvalid && adv;

  swam_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_accept    (in_accept),
    .in_op        (in_tuser),
    .in_letter    (in_tdata[swam_pkg::LETTER_W-1:0]),
    .adv          (adv),
    .item_o       (item),
    .item_valid_o (item_valid)
  );

  swam_count u_count (
    .clk          (clk),
    .rst_n        (rst_n),
    .adv          (adv),
    .item_i       (item),
    .item_valid_i (item_valid),
    .out_valid_o  (out_tvalid),
    .match_o      (match),
    .found_o      (found),
    .ovf_o        (ovf)
  );

  assign out_tdata = {5'b0, ovf, found, match};

endmodule
